// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define KNND_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define KNND_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `KNND_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/knnd_pkg.sv -----
// ----------------------------------------------------------------------------
// knnd_pkg
// Types, widths, codes and commands for the top-k nearest neighbor selector.
// ----------------------------------------------------------------------------
package knnd_pkg;

  localparam int MAX_KEEP_DEF = 64;

  localparam int ID_W   = 32;
  localparam int DIST_W = 32;
  localparam int NORM_W = 31;
  localparam int RANK_W = 6;
  localparam int KEEP_W = 7;

  // angular divider: |num| = |dot| << 16, den = (qn * cn >> 16) + 1
  localparam int PROD_W    = 2 * NORM_W;
  localparam int NUM_W     = DIST_W + 16;
  localparam int DEN_W     = PROD_W - 16 + 1;
  localparam int REM_W     = NUM_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = KEEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 1'd1;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 7'd10;

  typedef struct packed {
    logic [ID_W-1:0]          cand_id;
    logic signed [DIST_W-1:0] dot_product;
    logic [NORM_W-1:0]        candidate_norm;
    logic [NORM_W-1:0]        query_norm;
    logic                     last_cand;
  } cand_t;

  typedef struct packed {
    logic [ID_W-1:0]          out_id;
    logic signed [DIST_W-1:0] out_distance;
    logic [RANK_W-1:0]        rank;
    logic                     filled;
    logic                     last_result;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DEN,
    ST_DIV,
    ST_FIN,
    ST_INSERT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // capture the incoming candidate
    logic calc_eu;    // euclidean distance into the distance register
    logic calc_prod;  // norm product and numerator magnitude
    logic calc_den;   // denominator, clear remainder
    logic div_step;   // one quotient bit
    logic div_fin;    // sign and saturate the quotient
    logic insert;     // insert into the sorted list
    logic emit;       // move rank head to the output register, shift list up
  } cmd_t;

  typedef struct packed {
    logic metric_mode;
    logic last_cand;
  } dist_stat_t;

  typedef struct packed {
    logic out_free;
    logic emit_last;
  } list_stat_t;

endpackage

// ----- rtl/core/knn_distance_topk_select_core.sv -----
// ----------------------------------------------------------------------------
// knn_distance_topk_select_core
// Streaming top-k nearest neighbor selector with fixed-point distance.
// ----------------------------------------------------------------------------
// One candidate is handled at a time. A euclidean candidate passes capture,
// distance and insert before the next acceptance; an angular one passes
// capture, norm product, denominator, the bit-serial divider that forms the
// quotient one bit per cycle, sign and saturation, and insert. The list
// insertion updates all slots at once. A candidate flagged last is followed
// by keep_count result transactions (one to MAX_KEEP), one per cycle when
// the output is not stalled, during which no candidate is taken. A write to
// keep_count clears the list in the same cycle; no clearing pass after reset.
module knn_distance_topk_select_core #(
  parameter int MAX_KEEP = knnd_pkg::MAX_KEEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cand_valid,
  output logic                            cand_stall,
  input  knnd_pkg::cand_t                 cand,
  output logic                            res_valid,
  input  logic                            res_stall,
  output knnd_pkg::res_t                  res,
  input  logic                            cfg_we,
  input  logic [knnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knnd_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  knnd_pkg::cmd_t                      cmd;
  knnd_pkg::dist_stat_t                dstat;
  knnd_pkg::list_stat_t                lstat;
  logic signed [knnd_pkg::DIST_W-1:0]  cand_dist;
  logic [knnd_pkg::ID_W-1:0]           cand_id;

  knnd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .dstat      (dstat),
    .lstat      (lstat),
    .cmd        (cmd)
  );

  knnd_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .cand      (cand),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cand_dist (cand_dist),
    .cand_id   (cand_id),
    .stat      (dstat)
  );

  knnd_list #(
    .MAX_KEEP (MAX_KEEP)
  ) u_list (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cand_dist (cand_dist),
    .cand_id   (cand_id),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .stat      (lstat)
  );

  // an accepted candidate keeps the input stalled while it is processed
  `KNND_ASSERT_NEXT(a_busy_after_accept, clk, rst, cand_valid && !cand_stall, cand_stall, "accepted candidate did not stall input")
  // ranks of one query follow without gaps once the output is drained
  `KNND_ASSERT_NEXT(a_emit_continues, clk, rst, res_valid && !res_stall && !res.last_result, res_valid, "result stream broke before last rank")
  `KNND_ASSERT_NEXT(a_rank_step, clk, rst, res_valid && !res_stall && !res.last_result, res.rank == ($past(res.rank) + 6'd1), "rank did not advance by one")
  // no candidate is taken while ranks are still being emitted
  `KNND_ASSERT(a_no_accept_in_emit, clk, rst, cmd.emit |-> cand_stall, "candidate accepted during emission")

endmodule

// ----- rtl/core/knnd_ctrl.sv -----
// ----------------------------------------------------------------------------
// knnd_ctrl
// Sequencer: accept, distance, divide, insert and rank emission.
// ----------------------------------------------------------------------------
module knnd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cand_valid,
  output logic                 cand_stall,
  input  knnd_pkg::dist_stat_t dstat,
  input  knnd_pkg::list_stat_t lstat,
  output knnd_pkg::cmd_t       cmd
);

  knnd_pkg::ctrl_state_t state, state_next;
  logic [knnd_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  localparam logic [knnd_pkg::DIV_CNT_W-1:0] DIV_LAST =
    knnd_pkg::DIV_CNT_W'(knnd_pkg::NUM_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= knnd_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cand_stall   = 1'b1;
    unique case (state)
      knnd_pkg::ST_IDLE: begin
        cand_stall = 1'b0;
        if (cand_valid) begin
          cmd.load   = 1'b1;
          state_next = knnd_pkg::ST_PREP;
        end
      end
      knnd_pkg::ST_PREP: begin
        if (dstat.metric_mode) begin
          cmd.calc_prod = 1'b1;
          state_next    = knnd_pkg::ST_DEN;
        end else begin
          cmd.calc_eu = 1'b1;
          state_next  = knnd_pkg::ST_INSERT;
        end
      end
      knnd_pkg::ST_DEN: begin
        cmd.calc_den = 1'b1;
        div_cnt_next = '0;
        state_next   = knnd_pkg::ST_DIV;
      end
      knnd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) state_next = knnd_pkg::ST_FIN;
      end
      knnd_pkg::ST_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = knnd_pkg::ST_INSERT;
      end
      knnd_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = dstat.last_cand ? knnd_pkg::ST_EMIT : knnd_pkg::ST_IDLE;
      end
      knnd_pkg::ST_EMIT: begin
        if (lstat.out_free) begin
          cmd.emit = 1'b1;
          if (lstat.emit_last) state_next = knnd_pkg::ST_IDLE;
        end
      end
      default: state_next = knnd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/knnd_dist.sv -----
// ----------------------------------------------------------------------------
// knnd_dist
// Distance datapath: euclidean sum or angular quotient with a bit-serial
// restoring divider, saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module knnd_dist (
  input  logic                                 clk,
  input  logic                                 rst,
  input  knnd_pkg::cand_t                      cand,
  input  knnd_pkg::cmd_t                       cmd,
  input  logic                                 cfg_we,
  input  logic [knnd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [knnd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [knnd_pkg::DIST_W-1:0]   cand_dist,
  output logic [knnd_pkg::ID_W-1:0]            cand_id,
  output knnd_pkg::dist_stat_t                 stat
);

  knnd_pkg::cand_t                 item;
  logic                            metric_mode;
  logic [knnd_pkg::PROD_W-1:0]     prod;
  logic [knnd_pkg::DEN_W-1:0]      den;
  logic [knnd_pkg::NUM_W-1:0]      quo;
  logic [knnd_pkg::REM_W-1:0]      rem;
  logic                            neg;

  logic signed [knnd_pkg::DIST_W+1:0] eu_sum;
  logic signed [knnd_pkg::DIST_W-1:0] eu_sat;
  logic [knnd_pkg::DIST_W-1:0]        dot_u;
  logic [knnd_pkg::DIST_W-1:0]        dot_mag;
  logic [knnd_pkg::REM_W-1:0]         trial;
  logic                               trial_ge;
  logic signed [knnd_pkg::DIST_W-1:0] quo_sat;

  // qn + cn - dot fits in 34 bits signed
  assign eu_sum = $signed({3'b000, item.query_norm})
                + $signed({3'b000, item.candidate_norm})
                - (knnd_pkg::DIST_W+2)'(item.dot_product);

  always_comb begin
    if (eu_sum > (knnd_pkg::DIST_W+2)'(knnd_pkg::DIST_MAX))
      eu_sat = knnd_pkg::DIST_MAX;
    else if (eu_sum < (knnd_pkg::DIST_W+2)'(knnd_pkg::DIST_MIN))
      eu_sat = knnd_pkg::DIST_MIN;
    else
      eu_sat = eu_sum[knnd_pkg::DIST_W-1:0];
  end

  assign dot_u   = item.dot_product;
  assign dot_mag = dot_u[knnd_pkg::DIST_W-1] ? (~dot_u + 1'b1) : dot_u;

  // remainder stays below den, so its top bit is always clear
  assign trial    = {rem[knnd_pkg::REM_W-2:0], quo[knnd_pkg::NUM_W-1]};
  assign trial_ge = trial >= knnd_pkg::REM_W'(den);

  always_comb begin
    if (neg) begin
      if (quo > knnd_pkg::NUM_W'(48'h8000_0000))
        quo_sat = knnd_pkg::DIST_MIN;
      else
        quo_sat = ~quo[knnd_pkg::DIST_W-1:0] + 1'b1;
    end else begin
      if (quo > knnd_pkg::NUM_W'(48'h7FFF_FFFF))
        quo_sat = knnd_pkg::DIST_MAX;
      else
        quo_sat = quo[knnd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= 1'b0;
    end else if (cfg_we && cfg_index == knnd_pkg::REG_METRIC_MODE) begin
      metric_mode <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= cand;
    if (cmd.calc_eu) cand_dist <= eu_sat;
    if (cmd.calc_prod) begin
      prod <= knnd_pkg::PROD_W'(item.query_norm) * knnd_pkg::PROD_W'(item.candidate_norm);
      quo  <= {dot_mag, 16'h0000};
      // quotient is negative when the dot product is positive
      neg  <= !dot_u[knnd_pkg::DIST_W-1] && (dot_u != '0);
    end
    if (cmd.calc_den) begin
      den <= knnd_pkg::DEN_W'(prod[knnd_pkg::PROD_W-1:16]) + 1'b1;
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? (trial - knnd_pkg::REM_W'(den)) : trial;
      quo <= {quo[knnd_pkg::NUM_W-2:0], trial_ge};
    end
    if (cmd.div_fin) cand_dist <= quo_sat;
  end

  assign cand_id          = item.cand_id;
  assign stat.metric_mode = metric_mode;
  assign stat.last_cand   = item.last_cand;

endmodule

// ----- rtl/core/knnd_list.sv -----
// ----------------------------------------------------------------------------
// knnd_list
// Shifting sorted list of the nearest candidates, output register and
// rank emission by shifting the list toward the head.
// ----------------------------------------------------------------------------
module knnd_list #(
  parameter int MAX_KEEP = knnd_pkg::MAX_KEEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  knnd_pkg::cmd_t                      cmd,
  input  logic signed [knnd_pkg::DIST_W-1:0]  cand_dist,
  input  logic [knnd_pkg::ID_W-1:0]           cand_id,
  input  logic                                cfg_we,
  input  logic [knnd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [knnd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output knnd_pkg::res_t                      res,
  output knnd_pkg::list_stat_t                stat
);

  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  function automatic logic [IW-1:0] keep_m1_of(input logic [knnd_pkg::KEEP_W-1:0] kc);
    logic [IW-1:0] r;
    if (kc == '0)
      r = '0;
    else if (int'(kc) > MAX_KEEP)
      r = IW'(MAX_KEEP - 1);
    else
      r = IW'(kc - 1'b1);
    return r;
  endfunction

  logic signed [knnd_pkg::DIST_W-1:0] slot_dist [MAX_KEEP];
  logic [knnd_pkg::ID_W-1:0]          slot_id   [MAX_KEEP];
  logic [MAX_KEEP-1:0]                slot_vld;

  logic signed [knnd_pkg::DIST_W-1:0] prev_dist [MAX_KEEP];
  logic [knnd_pkg::ID_W-1:0]          prev_id   [MAX_KEEP];
  logic [MAX_KEEP-1:0]                prev_lt;
  logic [MAX_KEEP-1:0]                prev_vld;
  logic signed [knnd_pkg::DIST_W-1:0] nxt_dist  [MAX_KEEP];
  logic [knnd_pkg::ID_W-1:0]          nxt_id    [MAX_KEEP];
  logic [MAX_KEEP-1:0]                nxt_vld;
  logic [MAX_KEEP-1:0]                lt;
  logic [MAX_KEEP-1:0]                active;

  logic [IW-1:0] keep_m1;
  logic [IW-1:0] emit_cnt;
  logic          clear;

  assign clear = cfg_we && cfg_index == knnd_pkg::REG_KEEP_COUNT;

  // lt: the new distance goes ahead of this slot (empty slots always lose).
  // Strict compare keeps the earlier id ahead on ties.
  always_comb begin
    for (int c = 0; c < MAX_KEEP; c++) begin
      lt[c]     = !slot_vld[c] || (cand_dist < slot_dist[c]);
      active[c] = IW'(c) <= keep_m1;
    end
    prev_lt[0]   = 1'b0;
    prev_vld[0]  = 1'b0;
    prev_dist[0] = knnd_pkg::DIST_MAX;
    prev_id[0]   = '0;
    for (int c = 1; c < MAX_KEEP; c++) begin
      prev_lt[c]   = lt[c-1];
      prev_vld[c]  = slot_vld[c-1];
      prev_dist[c] = slot_dist[c-1];
      prev_id[c]   = slot_id[c-1];
    end
    for (int c = 0; c < MAX_KEEP - 1; c++) begin
      nxt_vld[c]  = slot_vld[c+1];
      nxt_dist[c] = slot_dist[c+1];
      nxt_id[c]   = slot_id[c+1];
    end
    nxt_vld[MAX_KEEP-1]  = 1'b0;
    nxt_dist[MAX_KEEP-1] = knnd_pkg::DIST_MAX;
    nxt_id[MAX_KEEP-1]   = '0;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_KEEP; c++) begin
      if (cmd.insert && active[c] && (prev_lt[c] || lt[c])) begin
        slot_dist[c] <= prev_lt[c] ? prev_dist[c] : cand_dist;
        slot_id[c]   <= prev_lt[c] ? prev_id[c]   : cand_id;
      end else if (cmd.emit) begin
        slot_dist[c] <= nxt_dist[c];
        slot_id[c]   <= nxt_id[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      slot_vld <= '0;
    end else begin
      for (int c = 0; c < MAX_KEEP; c++) begin
        if (cmd.insert && active[c] && (prev_lt[c] || lt[c]))
          slot_vld[c] <= prev_lt[c] ? prev_vld[c] : 1'b1;
        else if (cmd.emit)
          slot_vld[c] <= nxt_vld[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_m1 <= keep_m1_of(knnd_pkg::KEEP_COUNT_RST);
    end else if (clear) begin
      keep_m1 <= keep_m1_of(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        emit_cnt  <= stat.emit_last ? '0 : emit_cnt + 1'b1;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // head slot goes out; empty ranks read as the cleared values
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.out_id       <= slot_vld[0] ? slot_id[0] : '0;
      res.out_distance <= slot_vld[0] ? slot_dist[0] : knnd_pkg::DIST_MAX;
      res.rank         <= knnd_pkg::RANK_W'(emit_cnt);
      res.filled       <= slot_vld[0];
      res.last_result  <= stat.emit_last;
    end
  end

  assign stat.out_free  = !res_valid || !res_stall;
  assign stat.emit_last = emit_cnt == keep_m1;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the top-k nearest neighbor selector. Candidates are
// driven through the valid/stall channel, and a local copy of the sorted list
// predicts every ranked result. Each result is checked in order, field by
// field. Directed cases come first, then randomized queries under several
// keep_count and metric_mode settings, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS = knnd_pkg::MAX_KEEP_DEF;
  localparam logic [knnd_pkg::NORM_W-1:0] NORM_TOP = '1;
  localparam int SETTLE_CYCLES = 64;  // longer than an angular candidate takes

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cand_valid = 1'b0;
  logic                            cand_stall;
  knnd_pkg::cand_t                 cand = '0;
  logic                            res_valid;
  logic                            res_stall = 1'b0;
  knnd_pkg::res_t                  res;
  logic                            cfg_we = 1'b0;
  logic [knnd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [knnd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // sorted nearest-candidate list and settings as the block should hold them
  logic signed [knnd_pkg::DIST_W-1:0] near_dist [SLOTS];
  logic [knnd_pkg::ID_W-1:0]          near_id   [SLOTS];
  logic                               near_used [SLOTS];
  logic [knnd_pkg::KEEP_W-1:0]        keep_reg = knnd_pkg::KEEP_COUNT_RST;
  logic                               metric_sel = 1'b0;

  knnd_pkg::res_t pending_ranks [$];

  int errors = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_results = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  knn_distance_topk_select_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pause_cycles();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int kept_slots();
    if (keep_reg < 1) return 1;
    if (keep_reg > SLOTS) return SLOTS;
    return int'(keep_reg);
  endfunction

  task automatic clear_near_list();
    for (int s = 0; s < SLOTS; s++) begin
      near_dist[s] = knnd_pkg::DIST_MAX;
      near_id[s]   = '0;
      near_used[s] = 1'b0;
    end
  endtask

  function automatic logic signed [knnd_pkg::DIST_W-1:0] clamp_dist(longint v);
    if (v > longint'(knnd_pkg::DIST_MAX)) return knnd_pkg::DIST_MAX;
    if (v < longint'(knnd_pkg::DIST_MIN)) return knnd_pkg::DIST_MIN;
    return v[knnd_pkg::DIST_W-1:0];
  endfunction

  function automatic logic signed [knnd_pkg::DIST_W-1:0] candidate_distance(
      knnd_pkg::cand_t c);
    longint dot, qn, cn, den, num;
    longint unsigned prod;
    dot = longint'(c.dot_product);
    qn  = longint'(c.query_norm);
    cn  = longint'(c.candidate_norm);
    if (!metric_sel) return clamp_dist(qn + cn - dot);
    // Q32.32 product truncated to Q16.16, plus one LSB so it is never zero
    prod = qn * cn;
    den  = longint'(prod >> 16) + 1;
    num  = -dot * 65536;
    return clamp_dist(num / den);
  endfunction

  // insert one candidate; on the last one queue every rank and clear the list
  task automatic insert_candidate(knnd_pkg::cand_t c);
    int k, s;
    logic signed [knnd_pkg::DIST_W-1:0] d;
    knnd_pkg::res_t r;
    k = kept_slots();
    d = candidate_distance(c);
    if (!(near_used[k-1] && d >= near_dist[k-1])) begin
      s = k - 1;
      while (s > 0 && (!near_used[s-1] || d < near_dist[s-1])) begin
        near_dist[s] = near_dist[s-1];
        near_id[s]   = near_id[s-1];
        near_used[s] = near_used[s-1];
        s--;
      end
      near_dist[s] = d;
      near_id[s]   = c.cand_id;
      near_used[s] = 1'b1;
    end
    if (c.last_cand) begin
      for (s = 0; s < k; s++) begin
        r.out_id       = near_id[s];
        r.out_distance = near_dist[s];
        r.rank         = knnd_pkg::RANK_W'(s);
        r.filled       = near_used[s];
        r.last_result  = (s == k - 1);
        pending_ranks.push_back(r);
      end
      clear_near_list();
    end
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_rank(knnd_pkg::res_t got);
    knnd_pkg::res_t want;
    if (pending_ranks.size() == 0) begin
      report_mismatch($sformatf("unexpected result rank %0d id %h", got.rank, got.out_id));
      return;
    end
    want = pending_ranks.pop_front();
    n_results++;
    if (got.out_id !== want.out_id)
      report_mismatch($sformatf("rank %0d out_id %h, want %h",
                                want.rank, got.out_id, want.out_id));
    if (got.out_distance !== want.out_distance)
      report_mismatch($sformatf("rank %0d out_distance %h, want %h",
                                want.rank, got.out_distance, want.out_distance));
    if (got.rank !== want.rank)
      report_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
    if (got.filled !== want.filled)
      report_mismatch($sformatf("rank %0d filled %b, want %b",
                                want.rank, got.filled, want.filled));
    if (got.last_result !== want.last_result)
      report_mismatch($sformatf("rank %0d last_result %b, want %b",
                                want.rank, got.last_result, want.last_result));
  endtask

  // result side: check each transaction, then hold off for a random stretch
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        check_rank(res);
        stall_left = pause_cycles();
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // valid is kept high across back-to-back transactions
  task automatic push_candidate(knnd_pkg::cand_t c);
    int gap;
    gap = pause_cycles();
    if (gap > 0) begin
      cand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_valid <= 1'b1;
    cand       <= c;
    do @(posedge clk); while (cand_stall);
    insert_candidate(c);
    n_items++;
    if (c.last_cand) n_queries++;
  endtask

  // wait for every queued rank, then for the last candidate to finish
  task automatic drain();
    cand_valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [knnd_pkg::CFG_IDX_W-1:0] idx,
                           logic [knnd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == knnd_pkg::REG_KEEP_COUNT) begin
      keep_reg = data;
      clear_near_list();
    end else if (idx == knnd_pkg::REG_METRIC_MODE) begin
      metric_sel = data[0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic knnd_pkg::cand_t cand_of(logic [knnd_pkg::ID_W-1:0] id,
                                              logic signed [knnd_pkg::DIST_W-1:0] dot,
                                              logic [knnd_pkg::NORM_W-1:0] cn,
                                              logic [knnd_pkg::NORM_W-1:0] qn,
                                              bit last);
    knnd_pkg::cand_t c;
    c.cand_id        = id;
    c.dot_product    = dot;
    c.candidate_norm = cn;
    c.query_norm     = qn;
    c.last_cand      = last;
    return c;
  endfunction

  function automatic knnd_pkg::cand_t random_candidate(bit last);
    knnd_pkg::cand_t c;
    c.cand_id = $urandom;
    case ($urandom_range(0, 5))
      0, 1:    c.dot_product = $urandom;
      2:       c.dot_product = ($signed($urandom_range(0, 6)) - 3) <<< 14;
      3:       c.dot_product = $urandom_range(0, 1) ? knnd_pkg::DIST_MAX : knnd_pkg::DIST_MIN;
      default: c.dot_product = $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
    endcase
    case ($urandom_range(0, 3))
      0: begin
        c.candidate_norm = knnd_pkg::NORM_W'($urandom);
        c.query_norm     = knnd_pkg::NORM_W'($urandom);
      end
      1: begin
        c.candidate_norm = $urandom_range(0, 1) ? NORM_TOP : '0;
        c.query_norm     = $urandom_range(0, 1) ? NORM_TOP : '0;
      end
      2: begin
        // small pool, so equal distances show up often
        c.candidate_norm = knnd_pkg::NORM_W'($urandom_range(0, 3)) << 14;
        c.query_norm     = knnd_pkg::NORM_W'($urandom_range(0, 3)) << 14;
      end
      default: begin
        c.candidate_norm = knnd_pkg::NORM_W'($urandom_range(0, 32'h3FFFF));
        c.query_norm     = knnd_pkg::NORM_W'($urandom_range(0, 32'h3FFFF));
      end
    endcase
    c.last_cand = last;
    return c;
  endfunction

  // reset keep_count of 10: extremes of the fields, a tie, unfilled ranks
  task automatic test_basic_euclidean();
    push_candidate(cand_of(32'h0, 32'sh0, '0, '0, 1'b0));
    push_candidate(cand_of(32'hFFFF_FFFF, knnd_pkg::DIST_MIN, NORM_TOP, NORM_TOP, 1'b0));
    push_candidate(cand_of(32'h5, knnd_pkg::DIST_MAX, '0, '0, 1'b0));
    push_candidate(cand_of(32'h6, 32'sh0001_0000, 31'h8000, 31'h8000, 1'b0));
    push_candidate(cand_of(32'h7, -32'sd1, 31'h10, 31'h20, 1'b1));
  endtask

  task automatic test_keep_limits();
    drain();
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd1);
    push_candidate(cand_of(32'h1, 32'sd100, '0, '0, 1'b0));
    push_candidate(cand_of(32'h2, 32'sd200, '0, '0, 1'b0));
    push_candidate(cand_of(32'h3, 32'sd200, '0, '0, 1'b1));
    drain();
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd0);  // behaves as one slot
    push_candidate(cand_of(32'h4, 32'sd0, 31'd5, 31'd5, 1'b1));
    drain();
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd127);  // clamps to the full list
    push_candidate(cand_of(32'h8, 32'sd1, 31'd2, 31'd3, 1'b1));
  endtask

  // full list: larger or equal distances are dropped, ties go behind
  task automatic test_tie_and_drop();
    drain();
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd3);
    push_candidate(cand_of(32'd20, 32'sd0, '0, 31'd10, 1'b0));
    push_candidate(cand_of(32'd21, 32'sd0, '0, 31'd20, 1'b0));
    push_candidate(cand_of(32'd22, 32'sd0, '0, 31'd30, 1'b0));
    push_candidate(cand_of(32'd23, 32'sd0, '0, 31'd25, 1'b0));
    push_candidate(cand_of(32'd24, 32'sd0, '0, 31'd30, 1'b0));
    push_candidate(cand_of(32'd25, 32'sd0, '0, 31'd20, 1'b1));
  endtask

  task automatic test_angular_extremes();
    drain();
    write_reg(knnd_pkg::REG_METRIC_MODE, 7'd1);
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd4);
    push_candidate(cand_of(32'd10, knnd_pkg::DIST_MAX, '0, '0, 1'b0));
    push_candidate(cand_of(32'd11, knnd_pkg::DIST_MIN, '0, '0, 1'b0));
    push_candidate(cand_of(32'd12, 32'sh0001_0000, 31'h10000, 31'h10000, 1'b0));
    push_candidate(cand_of(32'd13, -32'sd3, NORM_TOP, NORM_TOP, 1'b1));
  endtask

  // mode change keeps the list, keep_count change clears it
  task automatic test_config_side_effects();
    push_candidate(cand_of(32'd30, 32'sh0002_0000, 31'h10000, 31'h10000, 1'b0));
    push_candidate(cand_of(32'd31, -32'sh0004_0000, 31'h10000, 31'h8000, 1'b0));
    drain();
    write_reg(knnd_pkg::REG_METRIC_MODE, 7'h7E);  // only bit 0 counts
    push_candidate(cand_of(32'd32, 32'sd0, 31'd7, 31'd9, 1'b1));
    push_candidate(cand_of(32'd33, 32'sd5, '0, '0, 1'b0));
    push_candidate(cand_of(32'd34, 32'sd6, '0, '0, 1'b0));
    drain();
    write_reg(knnd_pkg::REG_KEEP_COUNT, 7'd5);
    push_candidate(cand_of(32'd35, 32'sd1, 31'd4, 31'd4, 1'b1));
  endtask

  task automatic test_random_queries();
    int done, qlen;
    logic [knnd_pkg::KEEP_W-1:0] kc;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      kc = (phase == 0) ? 7'd64 :
           (phase == 1) ? 7'd1 :
           (phase < 5)  ? knnd_pkg::KEEP_W'($urandom_range(2, 12)) :
                          knnd_pkg::KEEP_W'($urandom_range(0, 127));
      write_reg(knnd_pkg::REG_KEEP_COUNT, kc);
      write_reg(knnd_pkg::REG_METRIC_MODE, {6'($urandom_range(0, 63)), phase[0]});
      done = 0;
      while (done < 14) begin
        calm = ($urandom_range(0, 3) == 0);
        qlen = $urandom_range(1, 12);
        for (int i = 0; i < qlen; i++) begin
          push_candidate(random_candidate(i == qlen - 1));
          done++;
        end
        if ($urandom_range(0, 5) == 0) drain();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    clear_near_list();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_euclidean();
    test_keep_limits();
    test_tie_and_drop();
    test_angular_extremes();
    test_config_side_effects();
    test_random_queries();
    drain();
    $display("covered %0d candidates in %0d queries, %0d ranked results checked",
             n_items, n_queries, n_results);
    $display("both metrics, keep_count 0 through 127, ties, drops and unfilled ranks");
    if (errors == 0 && pending_ranks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- knn_distance_topk_select_core.f -----
+incdir+rtl/core
rtl/core/knnd_pkg.sv
rtl/core/knnd_ctrl.sv
rtl/core/knnd_dist.sv
rtl/core/knnd_list.sv
rtl/core/knn_distance_topk_select_core.sv
bench/tb_top.sv
